### hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int FILL_W  = 5;
    localparam int STAT_W  = 2;
    localparam int IN_TDATA_W  = 2 * DATA_W;
    localparam int OUT_TDATA_W = ((DATA_W + FILL_W + 7) / 8) * 8;

    localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef logic signed [DATA_W-1:0] t_word;

    // Per-transaction control broadcast to every cell.
    typedef struct packed {
        logic ins;      // accepted insert on a queue that is not full
        logic rem;      // accepted remove on a queue that is not empty
        logic head_le;  // head priority is not above the new one
    } t_cell_ctl;

endpackage

### hw/rtl/spq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps

module spq_cell (
    input  logic              i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic              i_valid,
    input  spq_pkg::t_word    i_new_value,
    input  spq_pkg::t_word    i_new_pri,
    input  logic              i_left_ge,
    input  spq_pkg::t_word    i_left_value,
    input  spq_pkg::t_word    i_left_pri,
    input  spq_pkg::t_word    i_right_value,
    input  spq_pkg::t_word    i_right_pri,
    output logic              o_ge,
    output spq_pkg::t_word    o_value,
    output spq_pkg::t_word    o_pri
);
    import spq_pkg::*;

    t_word r_value;
    t_word r_pri;
    t_word n_value;
    t_word n_pri;

    // Slot sits at or past the insert point: empty, or new entry outranks it.
    assign o_ge = !i_valid || i_ctl.head_le || (r_pri < i_new_pri);

    always_comb begin
        n_value = r_value;
        n_pri   = r_pri;
        if (i_ctl.rem) begin
            n_value = i_right_value;
            n_pri   = i_right_pri;
        end else if (i_ctl.ins && o_ge) begin
            if (i_left_ge) begin
                n_value = i_left_value;
                n_pri   = i_left_pri;
            end else begin
                n_value = i_new_value;
                n_pri   = i_new_pri;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_pri   <= n_pri;
    end

    assign o_value = r_value;
    assign o_pri   = r_pri;

endmodule

### hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of slot cells plus count and result register.
// The result of a transaction is registered and valid in the cycle after it is accepted.
// Throughput: one insert or remove per cycle; all slots compare and shift in parallel.
// A waiting result does not stall input unless the downstream holds tready low.
// Reset (synchronous, active low) empties the queue and drops any pending result;
//   slot contents are not cleared, only slots below the count are ever read.
`timescale 1ns / 1ps

module sorted_priority_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] item_value, [63:32] item_priority
    input  logic [spq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] kind
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] head_value, [36:32] fill, [39:37] zero
    output logic [spq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [spq_pkg::STAT_W-1:0]        m_axis_tuser
);
    import spq_pkg::*;

    // Count of held entries.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Result register.
    logic              r_out_valid;
    t_word             r_head_value;
    logic [STAT_W-1:0] r_status;
    logic [FILL_W-1:0] r_fill;
    t_word             n_head_value;
    logic [STAT_W-1:0] n_status;

    logic  accept;
    logic  is_remove;
    logic  empty;
    logic  full;
    t_word new_value;
    t_word new_pri;

    t_cell_ctl ctl;

    // Cell row wiring.
    logic  valid   [DEPTH];
    logic  ge      [DEPTH];
    t_word value   [DEPTH];
    t_word pri     [DEPTH];

    assign new_value = s_axis_tdata[DATA_W-1:0];
    assign new_pri   = s_axis_tdata[2*DATA_W-1:DATA_W];
    assign is_remove = (s_axis_tuser == KIND_REMOVE);

    assign empty = (r_count == '0);
    assign full  = (r_count == CNT_W'(DEPTH));

    // Take a new transaction whenever the result slot is free or being drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Equal priority to the head places the new entry in front of it.
    assign ctl.ins     = accept && !is_remove && !full;
    assign ctl.rem     = accept && is_remove && !empty;
    assign ctl.head_le = !empty && (pri[0] <= new_pri);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign valid[gi] = (CNT_W'(gi) < r_count);

            if (gi == 0) begin : g_head
                spq_cell u_cell (
                    .i_clk         (i_clk),
                    .i_ctl         (ctl),
                    .i_valid       (valid[gi]),
                    .i_new_value   (new_value),
                    .i_new_pri     (new_pri),
                    .i_left_ge     (1'b0),
                    .i_left_value  (new_value),
                    .i_left_pri    (new_pri),
                    .i_right_value (value[gi+1]),
                    .i_right_pri   (pri[gi+1]),
                    .o_ge          (ge[gi]),
                    .o_value       (value[gi]),
                    .o_pri         (pri[gi])
                );
            end else if (gi == DEPTH - 1) begin : g_tail
                spq_cell u_cell (
                    .i_clk         (i_clk),
                    .i_ctl         (ctl),
                    .i_valid       (valid[gi]),
                    .i_new_value   (new_value),
                    .i_new_pri     (new_pri),
                    .i_left_ge     (ge[gi-1]),
                    .i_left_value  (value[gi-1]),
                    .i_left_pri    (pri[gi-1]),
                    .i_right_value (value[gi]),
                    .i_right_pri   (pri[gi]),
                    .o_ge          (ge[gi]),
                    .o_value       (value[gi]),
                    .o_pri         (pri[gi])
                );
            end else begin : g_mid
                spq_cell u_cell (
                    .i_clk         (i_clk),
                    .i_ctl         (ctl),
                    .i_valid       (valid[gi]),
                    .i_new_value   (new_value),
                    .i_new_pri     (new_pri),
                    .i_left_ge     (ge[gi-1]),
                    .i_left_value  (value[gi-1]),
                    .i_left_pri    (pri[gi-1]),
                    .i_right_value (value[gi+1]),
                    .i_right_pri   (pri[gi+1]),
                    .o_ge          (ge[gi]),
                    .o_value       (value[gi]),
                    .o_pri         (pri[gi])
                );
            end
        end
    endgenerate

    // Next count and result fields.
    always_comb begin
        n_count      = r_count;
        n_head_value = '0;
        n_status     = STATUS_DONE;
        if (is_remove) begin
            if (empty) begin
                n_status = STATUS_EMPTY;
            end else begin
                n_head_value = value[0];
                n_count      = r_count - CNT_W'(1);
            end
        end else begin
            if (full) begin
                n_status = STATUS_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the result: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head_value <= n_head_value;
            r_status     <= n_status;
            r_fill       <= FILL_W'(32'(n_count));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_fill, r_head_value});
    assign m_axis_tuser  = r_status;

endmodule

### hw/rtl/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps

module spq_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [spq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic [spq_pkg::STAT_W-1:0]        m_axis_tuser
);
    import spq_pkg::*;

    // A stalled result holds its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Remove on empty reports no value and zero fill.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_EMPTY |->
            m_axis_tdata[DATA_W-1:0] == '0 && m_axis_tdata[DATA_W+FILL_W-1:DATA_W] == '0)
        else $error("empty remove carries data");

    // Dropped insert reports no value and a full queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_FULL |->
            m_axis_tdata[DATA_W-1:0] == '0
            && m_axis_tdata[DATA_W+FILL_W-1:DATA_W] == FILL_W'(32'(DEPTH)))
        else $error("dropped insert inconsistent");

    // Reset leaves no result pending.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // Input is always taken when no result is waiting.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/spq_checker.sv
// Stream monitor, queue predictor and result comparison for the sorted priority queue.
`timescale 1ns / 1ps

module spq_scoreboard (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    input  logic                              i_s_axis_tready,
    input  logic [spq_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                              i_s_axis_tuser,
    input  logic                              i_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [spq_pkg::OUT_TDATA_W-1:0]   i_m_axis_tdata,
    input  logic [spq_pkg::STAT_W-1:0]        i_m_axis_tuser,
    input  logic                              i_end_of_test,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_inserts,
    output int                                o_removes,
    output int                                o_full_drops,
    output int                                o_empty_pops
);

    import spq_pkg::*;

    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        t_word              head_value;
        logic [STAT_W-1:0]  status;
        logic [FILL_W-1:0]  fill;
    } t_pop_result;

    // Shadow copy of the queue contents, head at index 0.
    t_word        shadow_value [DEPTH];
    t_word        shadow_prio  [DEPTH];
    int           shadow_held;
    t_pop_result  expected_q [$];

    int fail_count   = 0;
    int insert_count = 0;
    int remove_count = 0;
    int full_count   = 0;
    int empty_count  = 0;
    bit leftovers_checked = 1'b0;

    assign o_fail_count = fail_count;
    assign o_inserts    = insert_count;
    assign o_removes    = remove_count;
    assign o_full_drops = full_count;
    assign o_empty_pops = empty_count;

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINTS)
            $display("[%0t ns] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Apply one transaction to the shadow queue and return the result it must produce.
    function automatic t_pop_result queue_step(input logic kind, input t_word val,
                                               input t_word prio);
        t_pop_result res;
        int          pos;
        bit          found;
        res = '0;
        if (kind == KIND_REMOVE) begin
            remove_count++;
            if (shadow_held == 0) begin
                res.status = STATUS_EMPTY;
                empty_count++;
            end else begin
                res.head_value = shadow_value[0];
                for (int i = 1; i < shadow_held; i++) begin
                    shadow_value[i-1] = shadow_value[i];
                    shadow_prio[i-1]  = shadow_prio[i];
                end
                shadow_held--;
                res.status = STATUS_DONE;
            end
        end else begin
            insert_count++;
            if (shadow_held >= DEPTH) begin
                res.status = STATUS_FULL;
                full_count++;
            end else begin
                // Ties with the head go in front; ties further down go behind.
                if (shadow_held == 0 || shadow_prio[0] <= prio) begin
                    pos = 0;
                end else begin
                    pos   = shadow_held;
                    found = 1'b0;
                    for (int i = 1; i < shadow_held; i++) begin
                        if (!found && shadow_prio[i] < prio) begin
                            pos   = i;
                            found = 1'b1;
                        end
                    end
                end
                for (int i = shadow_held; i > pos; i--) begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_prio[i]  = shadow_prio[i-1];
                end
                shadow_value[pos] = val;
                shadow_prio[pos]  = prio;
                shadow_held++;
                res.status = STATUS_DONE;
            end
        end
        res.fill = shadow_held[FILL_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pop_result exp_r;
        t_pop_result got_r;
        logic [OUT_TDATA_W-DATA_W-FILL_W-1:0] pad;
        if (!i_rst_n) begin
            shadow_held = 0;
            expected_q.delete();
        end else begin
            // Predict before popping, so a same-edge result still finds its entry.
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_q.push_back(queue_step(i_s_axis_tuser,
                                                i_s_axis_tdata[DATA_W-1:0],
                                                i_s_axis_tdata[2*DATA_W-1:DATA_W]));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_r.head_value = i_m_axis_tdata[DATA_W-1:0];
                got_r.fill       = i_m_axis_tdata[DATA_W +: FILL_W];
                got_r.status     = i_m_axis_tuser;
                pad              = i_m_axis_tdata[OUT_TDATA_W-1:DATA_W+FILL_W];
                if (pad != '0)
                    report_mismatch($sformatf("padding bits not zero: %0h", pad));
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no transaction outstanding");
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got_r.head_value !== exp_r.head_value)
                        report_mismatch($sformatf("head_value got %0d want %0d",
                                                  got_r.head_value, exp_r.head_value));
                    if (got_r.status !== exp_r.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  got_r.status, exp_r.status));
                    if (got_r.fill !== exp_r.fill)
                        report_mismatch($sformatf("fill got %0d want %0d",
                                                  got_r.fill, exp_r.fill));
                end
            end
            if (i_end_of_test && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (expected_q.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived",
                                              expected_q.size()));
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

### tb/tb.sv
// Stimulus, flow control and verdict for the sorted priority queue testbench.
`timescale 1ns / 1ps

module tb;

    import spq_pkg::*;

    localparam int RANDOM_ITEMS  = 1300;
    localparam int END_WAIT_MAX  = 4000;

    typedef enum {SINK_OPEN, SINK_JITTER, SINK_CHOKED} t_sink_mode;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata;   // [31:0] item_value, [63:32] item_priority
    logic                     s_axis_tuser;   // [0] kind
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;   // [31:0] head_value, [36:32] fill, [39:37] zero
    logic [STAT_W-1:0]        m_axis_tuser;   // [1:0] status
    logic                     end_of_test;

    int fail_count, pending, inserts, removes, full_drops, empty_pops;

    // Source pacing: items left in the current burst.
    int burst_left = 0;

    // Sink pacing: mode and how long it holds.
    t_sink_mode sink_mode = SINK_OPEN;
    int         sink_left = 0;

    sorted_priority_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    spq_scoreboard checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_end_of_test   (end_of_test),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_inserts       (inserts),
        .o_removes       (removes),
        .o_full_drops    (full_drops),
        .o_empty_pops    (empty_pops)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a correct run finishes far earlier than this.
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Sink: switch between always ready, coin-flip ready and mostly stalled,
    // each mode holding for a random stretch of cycles.
    initial m_axis_tready = 1'b0;
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            case ($urandom_range(0, 2))
                0:       sink_mode <= SINK_OPEN;
                1:       sink_mode <= SINK_JITTER;
                default: sink_mode <= SINK_CHOKED;
            endcase
            sink_left <= $urandom_range(8, 64);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            SINK_OPEN:   m_axis_tready <= 1'b1;
            SINK_JITTER: m_axis_tready <= 1'($urandom_range(0, 1));
            default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Close the current burst when it runs out: drop valid, scribble junk on the
    // data lines (it must be ignored) and idle before the next burst.
    task automatic pace_source();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            s_axis_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
            // Now and then a long burst with no idling at all.
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // Present one transaction and hold it until the queue takes it.
    task automatic send_item(input logic kind, input t_word val, input t_word prio);
        pace_source();
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {prio, val};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Hold the source until every outstanding result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic t_word pick_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return t_word'($urandom_range(0, 8)) - 4;   // dense ties
            6, 7:             return t_word'($urandom);
            8: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7FFF_FFFF;
                    2:       return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            default:          return t_word'($urandom_range(0, 1)) + 32'sh7FFF_FFFE;
        endcase
    endfunction

    initial begin : stimulus
        bit    filling;
        int    phase_left;
        int    wait_cycles;
        logic  kind;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_INSERT;
        end_of_test   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pop from an empty queue first.
        send_item(KIND_REMOVE, 32'sh0, 32'sh0);
        // Extreme values and priorities; a tie with the head goes in front of it.
        send_item(KIND_INSERT, 32'sh7FFF_FFFF, 32'sh0);
        send_item(KIND_INSERT, 32'sh8000_0000, 32'sh0);
        send_item(KIND_INSERT, -32'sd1,        32'sh8000_0000);
        send_item(KIND_INSERT, 32'sh0,         32'sh7FFF_FFFF);
        // A tie below the head lands behind the other equal entries.
        send_item(KIND_INSERT, 32'sh1234,      32'sh0);
        // Removes with all-ones in the ignored fields.
        send_item(KIND_REMOVE, -32'sd1, -32'sd1);
        send_item(KIND_REMOVE, -32'sd1, -32'sd1);
        // Fill up to the brim with mixed ties, then overflow once.
        for (int i = 0; i < 14; i++)
            send_item(KIND_INSERT, 32'sh100 + i, t_word'(i % 3) - 1);

        // Let the queue settle before the random part.
        drain_results();

        // Random: alternate filling and draining phases so both the full and the
        // empty boundary are crossed many times, with a minority of opposite kinds.
        filling    = 1'b1;
        phase_left = $urandom_range(8, 40);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(8, 40);
            end
            phase_left--;
            if ($urandom_range(0, 3) == 0)
                kind = filling ? KIND_REMOVE : KIND_INSERT;
            else
                kind = filling ? KIND_INSERT : KIND_REMOVE;
            send_item(kind, t_word'($urandom), pick_priority());
            if (n % 300 == 299)
                drain_results();
        end

        // Wind down: stop the source and wait for the last results, bounded.
        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        do begin
            @(posedge i_clk);
            wait_cycles++;
        end while (pending != 0 && wait_cycles < END_WAIT_MAX);
        repeat (4) @(posedge i_clk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("Run covered %0d inserts (%0d refused on a full queue) and %0d removes",
                 inserts, full_drops, removes);
        $display("  (%0d on an empty queue), with source bursts and sink stalls mixed in.",
                 empty_pops);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
